// ===== rtl/bdasc_pkg.sv =====
// Shared constants and types for the binary to decimal ASCII converter.
package bdasc_pkg;

  localparam int ValueWidth = 32;
  localparam int NumDigits  = 10;
  localparam int DigitWidth = 4;
  localparam int BcdWidth   = NumDigits * DigitWidth;
  localparam int CharWidth  = 6;
  localparam int CountWidth = 5;

  // ASCII '0'; digits 0..9 map to 48..57, which fit in six bits
  localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

  // Last shift-adjust step and last digit slot
  localparam logic [CountWidth-1:0] LastShift = CountWidth'(ValueWidth - 1);
  localparam logic [CountWidth-1:0] LastSlot  = CountWidth'(NumDigits - 1);

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

// ===== rtl/binary_to_decimal_ascii.sv =====
// Top level: converts an unsigned 32-bit value to decimal ASCII digit words.
//
// Pulse start while busy is low to hand over in_value. The value goes through
// 32 shift-and-add-3 steps of one shared ten-digit BCD adjust unit, then ten
// digit slots are scanned most significant first; leading zeros are dropped,
// so one to ten digit words come out, one per cycle, each marked by out_valid
// for exactly one cycle, with out_last_digit set on the final digit. Zero gives
// the single digit '0'. Busy stays high from the start edge through the 32
// conversion steps and the 10 digit slots. The final digit word is shown in
// the first cycle after busy falls, and the next value can be taken at the end
// of that cycle, so a new value is only taken once the last one is through.
// The receiver cannot hold words off: it must take each one in the cycle it
// is shown.
module binary_to_decimal_ascii
  import bdasc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] in_value,
  output logic                  out_valid,
  output logic [CharWidth-1:0]  out_digit_char,
  output logic                  out_last_digit
);

  state_t                  state_r, state_nxt;
  logic [ValueWidth-1:0]   bin_r, bin_nxt;
  logic [BcdWidth-1:0]     bcd_r, bcd_nxt;
  logic [CountWidth-1:0]   cnt_r, cnt_nxt;
  logic                    started_r, started_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CharWidth-1:0]    out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [BcdWidth-1:0]     bcd_adj;
  logic [DigitWidth-1:0]   top_digit;
  logic                    top_nonzero;
  logic                    last_slot;

  // Adjust each BCD digit: add 3 where it is 5 or more
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_r[i*DigitWidth +: DigitWidth] >= DigitWidth'(5)) begin
        bcd_adj[i*DigitWidth +: DigitWidth] =
          bcd_r[i*DigitWidth +: DigitWidth] + DigitWidth'(3);
      end else begin
        bcd_adj[i*DigitWidth +: DigitWidth] = bcd_r[i*DigitWidth +: DigitWidth];
      end
    end
  end

  assign top_digit   = bcd_r[BcdWidth-1 -: DigitWidth];
  assign top_nonzero = (top_digit != '0);
  assign last_slot   = (cnt_r == LastSlot);

  // Sequence load, conversion and digit scan
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          bin_nxt     = in_value;
          bcd_nxt     = '0;
          cnt_nxt     = '0;
          started_nxt = 1'b0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        // Shift the next binary bit into the adjusted BCD word
        bcd_nxt = {bcd_adj[BcdWidth-2:0], bin_r[ValueWidth-1]};
        bin_nxt = {bin_r[ValueWidth-2:0], 1'b0};
        if (cnt_r == LastShift) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_EMIT: begin
        // Emit the top digit unless it is a leading zero
        if (top_nonzero || started_r || last_slot) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = AsciiZero | CharWidth'(top_digit);
          out_last_nxt  = last_slot;
        end
        started_nxt = started_r | top_nonzero;
        bcd_nxt     = {bcd_r[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
        if (last_slot) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

endmodule

// ===== sim/binary_to_decimal_ascii_tb.sv =====
// Self-checking testbench for the binary to decimal ASCII digit converter.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
  import bdasc_pkg::*;

  localparam int unsigned Radix       = 10;
  localparam int          RandomItems = 420;
  localparam int          QuietFirst  = 150;
  localparam int          QuietLast   = 259;
  localparam int          DrainCycles = 60;
  localparam int          CycleLimit  = 200000;
  localparam int          ReportLimit = 10;

  // One digit word as it leaves the converter
  typedef struct packed {
    logic [CharWidth-1:0] digit_char;
    logic                 last_digit;
  } digit_word_t;

  // Directed row: a value and, where obvious, its decimal text (zero means predict)
  typedef struct packed {
    logic [ValueWidth-1:0]  value;
    logic [NumDigits*8-1:0] text;
  } value_row_t;

  localparam int NumDirected = 18;

  value_row_t directed_rows [NumDirected] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{32'd99,         '0},
    '{32'd100,        '0},
    '{32'd4294967295, "4294967295"},
    '{32'd4294967294, '0},
    '{32'd2147483647, '0},
    '{32'd2147483648, "2147483648"},
    '{32'd1000000000, "1000000000"},
    '{32'd999999999,  '0},
    '{32'd4000000000, '0},
    '{32'hAAAAAAAA,   '0},
    '{32'h55555555,   '0},
    '{32'd0,          "0"},
    '{32'd12345,      '0},
    '{32'd4294967290, '0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [ValueWidth-1:0] in_value;
  logic                  out_valid;
  logic [CharWidth-1:0]  out_digit_char;
  logic                  out_last_digit;

  digit_word_t digit_queue [$];
  digit_word_t want_word;
  int          mismatch_count;
  int          cycle_count;

  binary_to_decimal_ascii DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Split the value into decimal digits and queue them most significant first
  function automatic void queue_decimal_digits(input logic [ValueWidth-1:0] value);
    logic [DigitWidth-1:0] rev [NumDigits];
    logic [ValueWidth-1:0] rest;
    digit_word_t           word;
    int                    count;
    rest  = value;
    count = 0;
    do begin
      rev[count] = DigitWidth'(rest % Radix);
      rest       = rest / Radix;
      count++;
    end while (rest != 0 && count < NumDigits);
    for (int k = count - 1; k >= 0; k--) begin
      word.digit_char = AsciiZero + CharWidth'(rev[k]);
      word.last_digit = (k == 0);
      digit_queue.push_back(word);
    end
  endfunction

  // Queue the typed-in text; the least significant character sits in byte 0
  function automatic void queue_text_digits(input logic [NumDigits*8-1:0] text);
    digit_word_t word;
    logic [7:0]  ch;
    for (int b = NumDigits - 1; b >= 0; b--) begin
      ch = text[b*8 +: 8];
      if (ch != 8'd0) begin
        word.digit_char = ch[CharWidth-1:0];
        word.last_digit = (b == 0);
        digit_queue.push_back(word);
      end
    end
  endfunction

  // Mix full-range, short, decade-boundary and near-maximum values
  function automatic logic [ValueWidth-1:0] random_value();
    logic [ValueWidth-1:0] decade;
    int                    k;
    decade = 32'd1;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 20);
      3: begin
        k = $urandom_range(1, NumDigits - 1);
        repeat (k) decade = decade * Radix;
        return decade - 1 + $urandom_range(0, 2);
      end
      default: return 32'hFFFFFFFF - $urandom_range(0, 5);
    endcase
  endfunction

  // Offer one value, optionally after an idle gap, and hold it until busy falls again
  task automatic send_value(input logic [ValueWidth-1:0] value,
                            input logic [NumDigits*8-1:0] text,
                            input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 60);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    if (text != '0) queue_text_digits(text);
    else queue_decimal_digits(value);
  endtask

  // Stimulus: reset, directed table, then random values
  initial begin
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      send_value(directed_rows[i].value, directed_rows[i].text, 1'b1);
    end
    for (int i = 0; i < RandomItems; i++) begin
      send_value(random_value(), '0, !(i >= QuietFirst && i <= QuietLast));
    end
    start <= 1'b0;

    // Drain the outstanding words, then allow for a stray late word
    while (digit_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && digit_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Check each digit word against the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (digit_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected digit word: char %0d last %b",
                   out_digit_char, out_last_digit);
      end else begin
        want_word = digit_queue.pop_front();
        if (out_valid !== 1'b1 || out_digit_char !== want_word.digit_char ||
            out_last_digit !== want_word.last_digit) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("digit word mismatch: expected char %0d last %b, got char %0d last %b",
                     want_word.digit_char, want_word.last_digit,
                     out_digit_char, out_last_digit);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
  end

endmodule
